// File: sv/gohist_pkg.sv
// ----------------------------------------------------------------------------
// gohist_pkg
// shared types and constants of the gradient orientation histogram block
// ----------------------------------------------------------------------------
`default_nettype none

package gohist_pkg;

	// patch geometry
	localparam int SUB_WINDOW = 8;
	localparam int PATCH_W    = 4;
	localparam logic [PATCH_W-1:0] PATCH_MID  = PATCH_W'(SUB_WINDOW - 1);
	localparam logic [PATCH_W-1:0] PATCH_SPAN = PATCH_W'(2 * SUB_WINDOW - 2);

	// histogram layout
	localparam int NUM_ORIENT = 8;
	localparam int ORIENT_W   = $clog2(NUM_ORIENT);
	localparam int NUM_QUAD   = 4;
	localparam int NUM_BINS   = NUM_QUAD * NUM_ORIENT;
	localparam int BIN_IDX_W  = $clog2(NUM_BINS);
	localparam int BIN_W      = 15;
	localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

	// sample fields
	localparam int PIX_W  = 8;
	localparam int POS_W  = 14;
	localparam int MAG_W  = PIX_W + 1;
	localparam int SIZE_W = 13;

	// stream widths
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 24;

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd1;
	localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(480);
	localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(640);

	// queue between classifier and accumulator
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// quadrant bit positions in op_t.quad
	localparam int QUAD_UL = 0;
	localparam int QUAD_UR = 1;
	localparam int QUAD_LL = 2;
	localparam int QUAD_LR = 3;

	// one classified sample
	typedef struct packed {
		logic [MAG_W-1:0]    mag;
		logic [ORIENT_W-1:0] bin;
		logic [NUM_QUAD-1:0] quad;
		logic                last;
	} op_t;

	typedef enum logic {
		ST_ACCUM,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic emitting;
		logic pop;
	} back_stat_t;

endpackage

`default_nettype wire

// File: sv/gradient_orientation_histogram.sv
// ----------------------------------------------------------------------------
// gradient_orientation_histogram
// 2x2 quadrant by 8 orientation gradient histogram over a 15x15 sample patch
// ----------------------------------------------------------------------------
// usage
//   slave stream: one pixel sample per transaction, tlast marks the final
//   sample of the patch; samples outside the image interior or patch add nothing
//   master stream: 32 bins per patch, quadrant UL, UR, LL, LR, eight
//   orientations each; tlast on the 32nd bin
//   config channel: cfg_index 0 = image_rows, 1 = image_cols; always ready,
//   write only while the block is idle
// timing
//   samples are taken one per cycle while the queue is not full; the classifier
//   pushes into a 4-entry queue and the accumulator retires one queued sample
//   per cycle outside the readout; a final sample passes the queue and the
//   readout state register before its first bin is registered onto m_tvalid;
//   the readout shifts the bin store one entry per cycle unless the receiver
//   stalls; while the readout runs the queue fills and s_tready drops once it is full
// reset
//   arst_n clears the bin store, queue and readout counter and loads
//   image_rows 480, image_cols 640
// stall
//   a held m_tready freezes the readout; the current bin stays on m_tdata
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_orientation_histogram
	import gohist_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// config write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	// sample stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// pix_left[7:0], pix_right[15:8], pix_up[23:16], pix_down[31:24],
	// pixel_row[45:32], pixel_col[59:46], patch_row[63:60], patch_col[67:64], zero pad
	input  wire logic [S_DATA_W-1:0]  s_tdata,
	input  wire logic                 s_tlast,
	// bin stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// bin_value[14:0], bin_index[19:15], zero pad
	output logic [M_DATA_W-1:0]       m_tdata,
	output logic                      m_tlast
);

	logic       q_push, q_full, q_valid, q_pop;
	op_t        push_op, head_op;
	back_stat_t b_stat;

	// config writes never wait
	assign cfg_ready = 1'b1;

	// front: classify each sample into magnitude, octant and quadrant mask
	gohist_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (push_op)
	);

	// decouples intake from readout stalls
	gohist_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.push_op(push_op),
		.full   (q_full),
		.valid  (q_valid),
		.head_op(head_op),
		.pop    (q_pop)
	);

	// back: accumulate bins, read out and clear on the final sample
	gohist_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (head_op),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.stat    (b_stat)
	);

	// queue is never written when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("sample queue overflow");

	// readout owns the bin store, nothing is retired meanwhile
	a_emit_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.emitting |-> !b_stat.pop)
		else $error("queue popped during readout");

	// a retired final sample starts the readout
	a_last_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(b_stat.pop && head_op.last) |=> b_stat.emitting)
		else $error("final sample did not start readout");

	// the descriptor closes on the highest bin index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[BIN_W +: BIN_IDX_W] == BIN_IDX_W'(NUM_BINS - 1)))
		else $error("tlast on wrong bin");

endmodule

`default_nettype wire

// File: sv/gohist_queue.sv
// ----------------------------------------------------------------------------
// gohist_queue
// short fifo of classified samples between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module gohist_queue
	import gohist_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	output logic      valid,
	output op_t       head_op,
	input  wire logic pop
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign head_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/gohist_front.sv
// ----------------------------------------------------------------------------
// gohist_front
// sample intake: interior check, gradient, octant and quadrant classification
// ----------------------------------------------------------------------------
`default_nettype none

module gohist_front
	import gohist_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_DATA_W-1:0]  s_tdata,
	input  wire logic                 s_tlast,
	input  wire logic                 q_full,
	output logic                      q_push,
	output op_t                       q_op
);

	logic [SIZE_W-1:0] rows_q;
	logic [SIZE_W-1:0] cols_q;

	logic [PIX_W-1:0]   left, right, up, down;
	logic signed [POS_W:0]   r_ext, c_ext, r_lim, c_lim;
	logic [PATCH_W-1:0] prow, pcol;
	logic signed [PIX_W:0] dx, dy;
	logic [PIX_W-1:0]   ax, ay;
	logic [MAG_W-1:0]   mag;
	logic               interior, in_patch, contrib;
	logic               top, bottom, lft, rgt;
	logic [ORIENT_W-1:0] bin;
	logic [NUM_QUAD-1:0] quad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_ROWS: rows_q <= cfg_data;
				REG_IMAGE_COLS: cols_q <= cfg_data;
				default:        rows_q <= rows_q;
			endcase
		end
	end

	always_comb begin
		left  = s_tdata[7:0];
		right = s_tdata[15:8];
		up    = s_tdata[23:16];
		down  = s_tdata[31:24];
		r_ext = $signed({s_tdata[45], s_tdata[45:32]});
		c_ext = $signed({s_tdata[59], s_tdata[59:46]});
		prow  = s_tdata[63:60];
		pcol  = s_tdata[67:64];

		// interior: 1 <= pos < size-1, all compares signed
		r_lim    = $signed({2'b00, rows_q}) - $signed((POS_W+1)'(1));
		c_lim    = $signed({2'b00, cols_q}) - $signed((POS_W+1)'(1));
		interior = (r_ext >= $signed((POS_W+1)'(1))) && (c_ext >= $signed((POS_W+1)'(1))) &&
		           (r_ext < r_lim) && (c_ext < c_lim);

		dx  = $signed({1'b0, right}) - $signed({1'b0, left});
		dy  = $signed({1'b0, down}) - $signed({1'b0, up});
		ax  = dx[PIX_W] ? PIX_W'(-dx) : dx[PIX_W-1:0];
		ay  = dy[PIX_W] ? PIX_W'(-dy) : dy[PIX_W-1:0];
		mag = {1'b0, ax} + {1'b0, ay};

		// octant from signs and a magnitude compare, boundaries go up
		if (!dy[PIX_W]) begin
			if (!dx[PIX_W] && dx != '0) bin = (ay < ax) ? 3'd0 : 3'd1;
			else if (dx == '0)          bin = 3'd2;
			else if (dy == '0)          bin = 3'd4;
			else                        bin = (ay > ax) ? 3'd2 : 3'd3;
		end else begin
			if (dx[PIX_W])              bin = (ay < ax) ? 3'd4 : 3'd5;
			else if (dx == '0)          bin = 3'd6;
			else                        bin = (ay > ax) ? 3'd6 : 3'd7;
		end

		// middle row and column sit in both halves
		in_patch = (prow <= PATCH_SPAN) && (pcol <= PATCH_SPAN);
		top      = (prow <= PATCH_MID);
		bottom   = (prow >= PATCH_MID);
		lft      = (pcol <= PATCH_MID);
		rgt      = (pcol >= PATCH_MID);
		contrib  = interior && in_patch && (mag != '0);

		quad          = '0;
		quad[QUAD_UL] = contrib && top && lft;
		quad[QUAD_UR] = contrib && top && rgt;
		quad[QUAD_LL] = contrib && bottom && lft;
		quad[QUAD_LR] = contrib && bottom && rgt;

		s_tready  = !q_full;
		q_push    = s_tvalid && !q_full && (contrib || s_tlast);
		q_op.mag  = mag;
		q_op.bin  = bin;
		q_op.quad = quad;
		q_op.last = s_tlast;
	end

endmodule

`default_nettype wire

// File: sv/gohist_back.sv
// ----------------------------------------------------------------------------
// gohist_back
// bin accumulation with saturation, descriptor readout and clear
// ----------------------------------------------------------------------------
`default_nettype none

module gohist_back
	import gohist_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire op_t                 q_op,
	output logic                     q_pop,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,
	output logic                     m_tlast,
	output back_stat_t               stat
);

	back_state_t state_q, state_d;
	logic [BIN_IDX_W-1:0] emit_cnt_q;
	logic [BIN_W-1:0]     store_q [NUM_BINS];

	logic                 out_valid_q;
	logic [BIN_W-1:0]     out_value_q;
	logic [BIN_IDX_W-1:0] out_index_q;
	logic                 out_last_q;

	logic                 out_free, emit_step, cnt_end;
	logic [BIN_W-1:0]     sat_sum [NUM_QUAD];
	logic [BIN_W:0]       wide_sum [NUM_QUAD];

	// one read and one saturating adder per quadrant
	always_comb begin
		for (int q = 0; q < NUM_QUAD; q++) begin
			wide_sum[q] = {1'b0, store_q[{2'(q), q_op.bin}]} + (BIN_W+1)'(q_op.mag);
			sat_sum[q]  = wide_sum[q][BIN_W] ? BIN_MAX : wide_sum[q][BIN_W-1:0];
		end
	end

	always_comb begin
		out_free  = !out_valid_q || m_tready;
		cnt_end   = (emit_cnt_q == BIN_IDX_W'(NUM_BINS - 1));
		q_pop     = 1'b0;
		emit_step = 1'b0;
		state_d   = state_q;
		case (state_q)
			ST_ACCUM: begin
				q_pop = q_valid;
				if (q_valid && q_op.last) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit_step = out_free;
				if (out_free && cnt_end) state_d = ST_ACCUM;
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACCUM;
			emit_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit_step) emit_cnt_q <= emit_cnt_q + 1'b1;
		end
	end

	// bin store: accumulate, or shift toward entry zero during readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) store_q[i] <= '0;
		end else if (emit_step) begin
			for (int i = 0; i < NUM_BINS - 1; i++) store_q[i] <= store_q[i+1];
			store_q[NUM_BINS-1] <= '0;
		end else if (q_pop) begin
			for (int q = 0; q < NUM_QUAD; q++) begin
				if (q_op.quad[q]) store_q[{2'(q), q_op.bin}] <= sat_sum[q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_step) begin
			out_value_q <= store_q[0];
			out_index_q <= emit_cnt_q;
			out_last_q  <= cnt_end;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign m_tdata       = {{(M_DATA_W - BIN_W - BIN_IDX_W){1'b0}}, out_index_q, out_value_q};
	assign m_tlast       = out_last_q;
	assign stat.emitting = (state_q == ST_EMIT);
	assign stat.pop      = q_pop;

endmodule

`default_nettype wire
